// File: rtl/core/fqs_pkg.sv
// shared types, codes and defaults for the searchable fifo queue
package fqs_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int IO_W           = 32;
  localparam int LEN_W          = 5;
  localparam int OUT_TDATA_W    = 40;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_FIND  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] data_out;
    logic               found;
    logic [LEN_W-1:0]   length;
  } result_t;

endpackage

// File: rtl/core/fqs_mem.sv
// entry store: one write port, one read port with registered read data
module fqs_mem #(
  parameter int DEPTH      = fqs_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = fqs_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= store[raddr];
    end
  end

endmodule

// File: rtl/core/fqs_ctrl.sv
// queue sequencer: pointers, count, command execution and search scan
module fqs_ctrl #(
  parameter int DEPTH      = fqs_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = fqs_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  fqs_pkg::cmd_t            in_cmd,
  input  logic signed [31:0]       in_data,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic [DATA_WIDTH-1:0]    mem_wdata,
  output logic                     mem_re,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  logic [DATA_WIDTH-1:0]    mem_rdata,
  output logic                     res_valid,
  input  logic                     res_ready,
  output fqs_pkg::result_t         res
);

  import fqs_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEQ_WAIT,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                 state;
  logic [ADDR_W-1:0]      head;
  logic [ADDR_W-1:0]      tail;
  logic [CNT_W-1:0]       count;
  cmd_t                   cmd_q;
  logic [DATA_WIDTH-1:0]  key;
  logic [ADDR_W-1:0]      ptr;
  logic [CNT_W-1:0]       issued;
  logic                   pend;

  logic signed [63:0]            in_wide;
  logic [DATA_WIDTH-1:0]         word_in;
  logic signed [DATA_WIDTH-1:0]  rd_s;
  logic signed [63:0]            rd_wide;
  logic                          full;
  logic                          empty;
  logic                          hit;
  logic                          scan_end;

  function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] i);
    return (i == ADDR_W'(DEPTH - 1)) ? '0 : i + ADDR_W'(1);
  endfunction

  assign in_wide   = 64'(in_data);
  assign word_in   = in_wide[DATA_WIDTH-1:0];
  assign rd_s      = mem_rdata;
  assign rd_wide   = 64'(rd_s);
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign hit       = pend && (mem_rdata == key);
  assign scan_end  = hit || (issued == count);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  assign mem_we    = (state == S_EXEC) && (cmd_q == CMD_ENQ) && !full;
  assign mem_waddr = tail;
  assign mem_wdata = key;
  assign mem_re    = ((state == S_EXEC) && (cmd_q == CMD_DEQ) && !empty) ||
                     ((state == S_SCAN) && (issued != count) && !hit);
  assign mem_raddr = (state == S_SCAN) ? ptr : head;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q  <= in_cmd;
            key    <= word_in;
            ptr    <= head;
            issued <= '0;
            pend   <= 1'b0;
            state  <= (in_cmd == CMD_FIND) ? S_SCAN : S_EXEC;
          end
        end
        S_EXEC: begin
          res.data_out <= '0;
          res.found    <= 1'b0;
          case (cmd_q)
            CMD_ENQ: begin
              state <= S_DONE;
              if (full) begin
                res.status <= ST_FULL;
                res.length <= LEN_W'(count);
              end else begin
                res.status <= ST_OK;
                tail       <= next_slot(tail);
                count      <= count + CNT_W'(1);
                res.length <= LEN_W'(count + CNT_W'(1));
              end
            end
            CMD_DEQ: begin
              res.length <= LEN_W'(count);
              if (empty) begin
                res.status <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                res.status <= ST_OK;
                state      <= S_DEQ_WAIT;
              end
            end
            CMD_CLEAR: begin
              res.status <= ST_OK;
              head       <= '0;
              tail       <= '0;
              count      <= '0;
              res.length <= '0;
              state      <= S_DONE;
            end
            default: begin
              res.status <= ST_OK;
              res.length <= LEN_W'(count);
              state      <= S_DONE;
            end
          endcase
        end
        S_DEQ_WAIT: begin
          res.data_out <= rd_wide[31:0];
          res.length   <= LEN_W'(count - CNT_W'(1));
          head         <= next_slot(head);
          count        <= count - CNT_W'(1);
          state        <= S_DONE;
        end
        S_SCAN: begin
          if (mem_re) begin
            ptr    <= next_slot(ptr);
            issued <= issued + CNT_W'(1);
          end
          if (scan_end) begin
            res.status   <= ST_OK;
            res.data_out <= '0;
            res.found    <= hit;
            res.length   <= LEN_W'(count);
            pend         <= 1'b0;
            state        <= S_DONE;
          end else begin
            pend <= mem_re;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> (head == tail))
    else $error("head and tail disagree with count");

  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("store written and read in one cycle");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (issued <= count))
    else $error("search read past the valid entries");

  a_write_grows: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (count == $past(count) + CNT_W'(1)))
    else $error("enqueue write without count increment");

endmodule

// File: rtl/core/fifo_queue_with_search.sv
// top level of the fifo queue with search: stream ports and result register
//
//   channel  | dir | tdata                        | tuser
//   s_axis   | in  | data_in                      | cmd
//   m_axis   | out | data_out, found, length, pad | status
//
// enqueue and clear pass through S_EXEC, dequeue also through S_DEQ_WAIT, search scans up to count entries
// (at most DEPTH): one store read per cycle during the scan
// a result register on m_axis lets the next request be taken while a result waits
// rst is synchronous and empties the queue; the store keeps stale words
// m_axis stall holds the sequencer once both the result register and its own result are full
module fifo_queue_with_search #(
  parameter int DEPTH      = fqs_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = fqs_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,  // data_in[31:0]
  input  logic [1:0]                      s_axis_tuser,  // cmd[1:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [fqs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // data_out[31:0], found, length[4:0], zero
  output logic [1:0]                      m_axis_tuser   // status[1:0]
);

  import fqs_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);

  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic                  res_valid;
  logic                  res_ready;
  result_t               res;
  result_t               out_res;

  fqs_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fqs_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (cmd_t'(s_axis_tuser)),
    .in_data   ($signed(s_axis_tdata)),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
      out_res       <= res;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {2'b00, out_res.length, out_res.found, out_res.data_out};
  assign m_axis_tuser = out_res.status;

endmodule

// File: tb/sv/fifo_queue_with_search_tb.sv
// self-checking testbench for the searchable fifo queue, stream requests against a predictor
`timescale 1ns / 100ps

module fifo_queue_with_search_tb;
  import fqs_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE       = 40;
  localparam int N_RANDOM     = 1225;
  localparam int CALM_TAIL    = 150;
  localparam int WAIT_LIMIT   = 20000;

  class queue_scoreboard;
    logic [31:0] words [DEPTH];
    int          head;
    int          tail;
    int          count;
    result_t     due [$];
    int          errors;
    int          checked;
    int          full_hits;
    int          empty_hits;
    int          found_hits;
    int          peak_len;
    int          cmd_seen [4];

    function int next_slot(int i);
      return (i == DEPTH - 1) ? 0 : i + 1;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function logic [31:0] pick_held_key();
      if (count == 0) return $urandom;
      return words[(head + $urandom_range(0, count - 1)) % DEPTH];
    endfunction

    function void note_request(cmd_t c, logic [31:0] d);
      result_t r;
      int      idx;
      r = '0;
      r.status = ST_OK;
      cmd_seen[int'(c)]++;
      case (c)
        CMD_ENQ: begin
          if (count >= DEPTH) begin
            r.status = ST_FULL;
            full_hits++;
          end else begin
            words[tail] = d;
            tail = next_slot(tail);
            count++;
          end
        end
        CMD_DEQ: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
            empty_hits++;
          end else begin
            r.data_out = words[head];
            head = next_slot(head);
            count--;
          end
        end
        CMD_FIND: begin
          idx = head;
          for (int k = 0; k < count; k++) begin
            if (words[idx] == d) begin
              r.found = 1'b1;
              found_hits++;
              break;
            end
            idx = next_slot(idx);
          end
        end
        default: begin
          head = 0;
          tail = 0;
          count = 0;
        end
      endcase
      r.length = count[LEN_W-1:0];
      if (count > peak_len) peak_len = count;
      due.push_back(r);
    endfunction

    function void check_result(status_t st, logic [31:0] dout, logic fnd, logic [LEN_W-1:0] len);
      result_t r;
      if (due.size() == 0) begin
        $error("result with no request pending: status %0d data_out %h", st, dout);
        errors++;
        return;
      end
      r = due.pop_front();
      checked++;
      if (st !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, st);
        errors++;
      end
      if (dout !== r.data_out) begin
        $error("data_out: expected %h, actual %h", r.data_out, dout);
        errors++;
      end
      if (fnd !== r.found) begin
        $error("found: expected %0d, actual %0d", r.found, fnd);
        errors++;
      end
      if (len !== r.length) begin
        $error("length: expected %0d, actual %0d", r.length, len);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [31:0]            s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;

  queue_scoreboard sb;
  bit              idle_on;
  bit              long_hold;
  int              stall_cycles;

  fifo_queue_with_search #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH_DEF)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // result side: short random stalls, plus one long hold-off on demand
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(cmd_t'(s_axis_tuser), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(status_t'(m_axis_tuser), m_axis_tdata[31:0], m_axis_tdata[32],
                        m_axis_tdata[33 +: LEN_W]);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_req(input cmd_t c, input logic [31:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= c;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // hold the request side until every outstanding result is back
  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       w = 32'h8000_0000;
          1:       w = 32'h7FFF_FFFF;
          2:       w = 32'h0000_0000;
          default: w = 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: begin
        w = $urandom_range(0, 7);
        if ($urandom_range(0, 1)) w = -w;
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  initial begin
    logic [31:0] edge_words [16];
    int          mode;
    int          pick;
    int          waits;
    cmd_t        c;
    logic [31:0] d;

    edge_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'h8000_0001,
                   32'h7FFF_FFFE, 32'hFFFF_FFFE, 32'h0000_0001, 32'h0F0F_0F0F,
                   32'hF0F0_F0F0, 32'h3333_3333, 32'hCCCC_CCCC, 32'h1234_5678};
    sb            = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_ENQ;
    idle_on       = 1'b1;
    long_hold     = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty queue, fill to the brim, refused request, searches at both ends, clear
    send_req(CMD_DEQ, 32'hFFFF_FFFF);
    send_req(CMD_FIND, 32'h0000_0000);
    for (int i = 0; i < 16; i++) send_req(CMD_ENQ, edge_words[i]);
    send_req(CMD_ENQ, 32'h0BAD_F00D);
    send_req(CMD_FIND, 32'h8000_0000);
    send_req(CMD_FIND, 32'h1234_5678);
    send_req(CMD_FIND, 32'hDEAD_BEEF);
    send_req(CMD_DEQ, 32'h0000_0000);
    send_req(CMD_CLEAR, 32'hA5A5_A5A5);
    send_req(CMD_DEQ, 32'h0000_0000);

    mode = 2;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      if (n == 300) long_hold = 1'b1;
      if (n == 650) drain_wait();
      if (n == N_RANDOM - CALM_TAIL) idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      case (mode)
        0:       c = (pick < 65) ? CMD_ENQ : (pick < 80) ? CMD_DEQ :
                     (pick < 98) ? CMD_FIND : CMD_CLEAR;
        1:       c = (pick < 15) ? CMD_ENQ : (pick < 75) ? CMD_DEQ :
                     (pick < 98) ? CMD_FIND : CMD_CLEAR;
        default: c = (pick < 35) ? CMD_ENQ : (pick < 70) ? CMD_DEQ :
                     (pick < 97) ? CMD_FIND : CMD_CLEAR;
      endcase
      if (c == CMD_FIND && $urandom_range(0, 1))
        d = sb.pick_held_key();
      else
        d = rand_word();
      send_req(c, d);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    waits = 0;
    while (sb.pending() != 0 && waits < WAIT_LIMIT) begin
      @(posedge clk);
      waits++;
    end
    repeat (SETTLE) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end

    $display("run covered %0d enqueue, %0d dequeue, %0d search and %0d clear requests, %0d results",
             sb.cmd_seen[0], sb.cmd_seen[1], sb.cmd_seen[2], sb.cmd_seen[3], sb.checked);
    $display("full refusals %0d, empty dequeues %0d, search hits %0d, peak length %0d",
             sb.full_hits, sb.empty_hits, sb.found_hits, sb.peak_len);
    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
